>>> src/frlm_pkg.sv
// ----------------------------------------------------------------------------
// frlm_pkg: shared constants for the frame rate limiter and meter
// Field widths, reset values and rate-meter constants used by the block and
// its divider.
// ----------------------------------------------------------------------------
package frlm_pkg;

	localparam int TIME_W          = 32;
	localparam int DELAY_W         = 16;
	localparam int FPS_W           = 22;
	localparam int PHASE_W         = 4;
	localparam int NUM_W           = 24;

	localparam int WINDOW_SIZE_DEF = 10;
	localparam int TARGET_RESET    = 16;
	localparam int ANNOUNCE_EVERY  = 10;
	localparam int FPS_SCALE       = 256000;

	localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

endpackage

>>> src/frame_rate_limiter_and_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_limiter_and_meter: frame pacing delay and averaged frame rate
// Each transaction on the input channel is one frame-end event with a
// millisecond timestamp and a track flag; each produces one result.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, now_ms, track) takes one frame-end
// event at a time. in_stall is high from the cycle after a transaction until
// the block has produced its result. The output channel (out_valid,
// out_stall, delay_ms, fps_q8, announce) holds each result in a register
// until it is taken, so the next event can be accepted while a result waits.
// An untracked event skips the rate meter and goes from the delay step
// straight to its result. A tracked event updates the sample ring and a
// running sum, then runs a restoring divider that yields one quotient bit
// per cycle. If the output register still holds a stalled result when a
// new result is ready, the block keeps it until the output register is free.
// target_frame_ms is written over the cfg channel, which is always ready;
// write it only while the block is idle. Reset clears the frame timing, the
// rate meter and the output channel, and sets target_frame_ms to 16.
// ----------------------------------------------------------------------------
module frame_rate_limiter_and_meter #(
	parameter int WINDOW_SIZE = frlm_pkg::WINDOW_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [frlm_pkg::TIME_W-1:0]  now_ms,
	input  logic                         track,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [frlm_pkg::DELAY_W-1:0] delay_ms,
	output logic [frlm_pkg::FPS_W-1:0]   fps_q8,
	output logic                         announce,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [frlm_pkg::DELAY_W-1:0] cfg_data
);

	localparam int TIME_W  = frlm_pkg::TIME_W;
	localparam int DELAY_W = frlm_pkg::DELAY_W;
	localparam int FPS_W   = frlm_pkg::FPS_W;
	localparam int NUM_W   = frlm_pkg::NUM_W;
	localparam int PHASE_W = frlm_pkg::PHASE_W;
	localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W   = TIME_W + ((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 0);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CALC   = 7'b0000010,
		S_SAMPLE = 7'b0000100,
		S_ACCUM  = 7'b0001000,
		S_START  = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [DELAY_W-1:0]   target_q;
	logic [TIME_W-1:0]    frame_start_q;
	logic [TIME_W-1:0]    last_end_q;
	logic                 last_valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     filled_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 out_valid_q;

	logic [TIME_W-1:0]    now_q;
	logic                 track_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [TIME_W-1:0]    end_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [TIME_W-1:0]    sample_q;
	logic                 ann_q;
	logic [TIME_W-1:0]    rd_data_q;
	logic [TIME_W-1:0]    ring [WINDOW_SIZE];
	logic [DELAY_W-1:0]   delay_ms_q;
	logic [FPS_W-1:0]     fps_q8_q;
	logic                 announce_q;

	logic                 accept;
	logic                 full;
	logic                 out_load;
	logic [DELAY_W-1:0]   delay_c;
	logic [TIME_W-1:0]    end_c;
	logic [TIME_W-1:0]    sample_c;
	logic [PHASE_W-1:0]   phase_next;
	logic [NUM_W-1:0]     numerator;
	logic                 div_done;
	logic [NUM_W-1:0]     quotient;
	logic [FPS_W-1:0]     fps_c;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign full      = (filled_q == CNT_W'(WINDOW_SIZE));
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign delay_c    = (elapsed_q < {{(TIME_W-DELAY_W){1'b0}}, target_q})
	                    ? DELAY_W'(target_q - elapsed_q[DELAY_W-1:0]) : '0;
	assign end_c      = now_q + {{(TIME_W-DELAY_W){1'b0}}, delay_c};
	assign sample_c   = last_valid_q ? (end_q - last_end_q) : '0;
	assign phase_next = (phase_q == PHASE_W'(frlm_pkg::ANNOUNCE_EVERY - 1))
	                    ? '0 : phase_q + 1'b1;
	assign numerator  = NUM_W'(frlm_pkg::FPS_SCALE) * NUM_W'(filled_q);

	always_comb begin
		if (!track_q || sum_q == '0) begin
			fps_c = '0;
		end else if (quotient[NUM_W-1:FPS_W] != '0) begin
			fps_c = frlm_pkg::FPS_MAX;
		end else begin
			fps_c = quotient[FPS_W-1:0];
		end
	end

	frlm_div #(
		.DIVISOR_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (numerator),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			target_q      <= DELAY_W'(frlm_pkg::TARGET_RESET);
			frame_start_q <= '0;
			last_end_q    <= '0;
			last_valid_q  <= 1'b0;
			slot_q        <= '0;
			filled_q      <= '0;
			phase_q       <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					frame_start_q <= end_c;
					state_q       <= track_q ? S_SAMPLE : S_DONE;
				end
				S_SAMPLE: begin
					sum_q   <= full ? SUM_W'(sum_q - {{(SUM_W-TIME_W){1'b0}}, rd_data_q}) : sum_q;
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					sum_q        <= SUM_W'(sum_q + {{(SUM_W-TIME_W){1'b0}}, sample_q});
					last_end_q   <= end_q;
					last_valid_q <= 1'b1;
					slot_q       <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
					filled_q     <= full ? filled_q : filled_q + 1'b1;
					phase_q      <= phase_next;
					state_q      <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= ring[slot_q];
		if (accept) begin
			now_q     <= now_ms;
			track_q   <= track;
			elapsed_q <= now_ms - frame_start_q;
		end
		if (state_q == S_CALC) begin
			delay_q <= delay_c;
			end_q   <= end_c;
			ann_q   <= 1'b0;
		end
		if (state_q == S_SAMPLE) begin
			ring[slot_q] <= sample_c;
			sample_q     <= sample_c;
		end
		if (state_q == S_ACCUM) begin
			ann_q <= (phase_next == '0);
		end
		if (out_load) begin
			delay_ms_q <= delay_q;
			fps_q8_q   <= fps_c;
			announce_q <= ann_q;
		end
	end

	assign out_valid = out_valid_q;
	assign delay_ms  = delay_ms_q;
	assign fps_q8    = fps_q8_q;
	assign announce  = announce_q;

endmodule

>>> src/frlm_div.sv
// ----------------------------------------------------------------------------
// frlm_div: restoring unsigned divider
// Produces one quotient bit per cycle for a NUM_W-bit dividend and a
// DIVISOR_W-bit divisor. done pulses for one cycle.
// ----------------------------------------------------------------------------
module frlm_div #(
	parameter int DIVISOR_W = 36
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [frlm_pkg::NUM_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]       divisor,
	output logic                       done,
	output logic [frlm_pkg::NUM_W-1:0] quotient
);

	localparam int NUM_W = frlm_pkg::NUM_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [NUM_W-1:0]     dvd_q;
	logic [NUM_W-1:0]     quot_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			dvd_q     <= dividend;
			quot_q    <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= DIVISOR_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

>>> src/frlm_checker.sv
// ----------------------------------------------------------------------------
// frlm_checker: port-level checks for the frame rate limiter and meter
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module frlm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [frlm_pkg::TIME_W-1:0]  now_ms,
	input logic                         track,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [frlm_pkg::DELAY_W-1:0] delay_ms,
	input logic [frlm_pkg::FPS_W-1:0]   fps_q8,
	input logic                         announce,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [frlm_pkg::DELAY_W-1:0] cfg_data
);

	// After an input transaction the block stays busy and holds in_stall high.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall ##1 in_stall)
		else $error("input accepted again too soon after a transaction");

	// A stalled result keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(delay_ms)
		&& $stable(fps_q8) && $stable(announce)))
		else $error("stalled result changed");

	// A result appears only while an event is being worked on.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no event in progress");

	// An untracked frame taken while the output is empty shows no rate and
	// no announcement once its result is presented.
	a_untracked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !track && !out_valid)
		|-> ##3 (out_valid && !announce && fps_q8 == '0))
		else $error("untracked frame reported a rate");

endmodule

bind frame_rate_limiter_and_meter frlm_checker u_frlm_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for frame_rate_limiter_and_meter
// Drives frame-end events and target writes, and predicts each delay,
// averaged rate and announce flag with a model of its own. The results are
// compared in order, field by field, with random idling in most segments.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int IDLE_GUARD     = 40;
	localparam int ITEMS_PER_SEG  = 136;
	localparam int NUM_SEGS       = 12;

	typedef struct packed {
		logic [frlm_pkg::DELAY_W-1:0] delay;
		logic [frlm_pkg::FPS_W-1:0]   fps;
		logic                         announce;
	} pace_result_t;

	class frame_pace_model;
		logic [frlm_pkg::DELAY_W-1:0] target;
		logic [frlm_pkg::TIME_W-1:0]  frame_start;
		logic [frlm_pkg::TIME_W-1:0]  last_end;
		bit                           last_valid;
		logic [frlm_pkg::TIME_W-1:0]  ring [frlm_pkg::WINDOW_SIZE_DEF];
		int unsigned                  slot;
		int unsigned                  filled;
		int unsigned                  phase;
		int unsigned                  mismatches;
		pace_result_t                 expected_q[$];

		function new();
			target      = frlm_pkg::TARGET_RESET;
			frame_start = '0;
			last_end    = '0;
			last_valid  = 1'b0;
			slot        = 0;
			filled      = 0;
			phase       = 0;
			mismatches  = 0;
		endfunction

		function logic [frlm_pkg::FPS_W-1:0] rate_q8();
			logic [63:0] total;
			logic [63:0] q;
			total = '0;
			for (int i = 0; i < filled; i++)
				total += 64'(ring[i]);
			if (filled == 0 || total == 0)
				return '0;
			q = (64'(frlm_pkg::FPS_SCALE) * 64'(filled)) / total;
			if (q > 64'(frlm_pkg::FPS_MAX))
				return frlm_pkg::FPS_MAX;
			return q[frlm_pkg::FPS_W-1:0];
		endfunction

		function void note_event(logic [frlm_pkg::TIME_W-1:0] now, logic trk);
			logic [frlm_pkg::TIME_W-1:0] elapsed;
			logic [frlm_pkg::TIME_W-1:0] stop;
			pace_result_t                r;
			r = '0;
			elapsed = now - frame_start;
			if (frlm_pkg::TIME_W'(target) > elapsed)
				r.delay = target - elapsed[frlm_pkg::DELAY_W-1:0];
			stop = now + frlm_pkg::TIME_W'(r.delay);
			if (trk) begin
				ring[slot] = last_valid ? stop - last_end : '0;
				last_end   = stop;
				last_valid = 1'b1;
				slot       = (slot + 1 == frlm_pkg::WINDOW_SIZE_DEF) ? 0 : slot + 1;
				if (filled < frlm_pkg::WINDOW_SIZE_DEF)
					filled++;
				phase      = (phase + 1 == frlm_pkg::ANNOUNCE_EVERY) ? 0 : phase + 1;
				r.announce = (phase == 0);
				r.fps      = rate_q8();
			end
			frame_start = stop;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("ERROR: %s", msg);
			mismatches++;
		endtask

		task check_result(logic [frlm_pkg::DELAY_W-1:0] d, logic [frlm_pkg::FPS_W-1:0] f,
			logic a);
			pace_result_t r;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result delay=%0d fps=%0d announce=%0b",
					d, f, a));
				return;
			end
			r = expected_q.pop_front();
			if (d !== r.delay)
				report($sformatf("delay_ms got %0d, want %0d", d, r.delay));
			if (f !== r.fps)
				report($sformatf("fps_q8 got %0d, want %0d", f, r.fps));
			if (a !== r.announce)
				report($sformatf("announce got %0b, want %0b", a, r.announce));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [frlm_pkg::TIME_W-1:0]  now_ms;
	logic                         track;
	logic                         out_valid;
	logic                         out_stall;
	logic [frlm_pkg::DELAY_W-1:0] delay_ms;
	logic [frlm_pkg::FPS_W-1:0]   fps_q8;
	logic                         announce;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [frlm_pkg::DELAY_W-1:0] cfg_data;

	frame_pace_model model;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	int unsigned     quiet_cycles = 0;

	frame_rate_limiter_and_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.now_ms    (now_ms),
		.track     (track),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.delay_ms  (delay_ms),
		.fps_q8    (fps_q8),
		.announce  (announce),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			model.check_result(delay_ms, fps_q8, announce);
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("frame_rate_limiter_and_meter: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_event(input logic [frlm_pkg::TIME_W-1:0] t, input logic trk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms   <= t;
		track    <= trk;
		do @(posedge clk); while (in_stall);
		model.note_event(t, trk);
	endtask

	task automatic send_random();
		logic [frlm_pkg::TIME_W-1:0] t;
		int unsigned                 pick;
		int unsigned                 span;
		pick = $urandom_range(99);
		span = 2 * model.target + 4;
		if (pick < 65)
			t = model.frame_start + $urandom_range(span);
		else if (pick < 80)
			t = model.frame_start + $urandom_range(3);
		else if (pick < 88)
			t = model.frame_start - $urandom_range(1000, 1);
		else
			t = $urandom;
		send_event(t, $urandom_range(99) < 75);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (model.expected_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic write_target(input logic [frlm_pkg::DELAY_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model.target = v;
	endtask

	initial begin
		model         = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		now_ms        = '0;
		track         = 1'b0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		send_idle_pct = 22;
		recv_idle_pct = 68;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first tracked frame stores a zero sample, so the rate is zero.
		send_event('0, 1'b1);
		send_event('0, 1'b0);
		send_event('1, 1'b1);
		send_event(32'h0000_0002, 1'b1);
		// Enough tracked frames to wrap the ring and raise announce.
		repeat (12) send_event(model.frame_start + 3, 1'b1);
		send_event(model.frame_start + 40, 1'b0);
		wait_results_done();
		write_target('1);
		send_event(model.frame_start, 1'b1);
		send_event(model.frame_start + 65534, 1'b1);
		wait_results_done();
		write_target('0);
		send_event(model.frame_start, 1'b1);
		send_event(model.frame_start + 1, 1'b1);

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			send_idle_pct = (seg < 4) ? 22 : (seg < 8) ? 68 : 0;
			recv_idle_pct = (seg < 4) ? 68 : (seg < 8) ? 22 : 0;
			wait_results_done();
			case (seg % 4)
				0: begin
					write_target(frlm_pkg::DELAY_W'(frlm_pkg::TARGET_RESET));
				end
				1: begin
					write_target('0);
				end
				2: begin
					write_target('1);
				end
				default: begin
					write_target((seg > 8) ? frlm_pkg::DELAY_W'($urandom) :
						frlm_pkg::DELAY_W'($urandom_range(100, 1)));
				end
			endcase
			repeat (ITEMS_PER_SEG) send_random();
		end

		wait_results_done();
		if (model.mismatches == 0 && model.expected_q.size() == 0)
			$display("frame_rate_limiter_and_meter: match");
		else
			$display("frame_rate_limiter_and_meter: mismatch");
		$finish;
	end
endmodule
